/* hw/rtl/lmx_pkg.sv */
// Shared constants, event codes and control structs for the mutual exclusion node.
// Used by lmx_ctrl, lmx_dp and the lamport_mutex_node top level; depends on nothing.
`default_nettype none

package lmx_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = 4;
  localparam int STAMP_W   = 15;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 4;

  localparam logic [STAMP_W-1:0] NO_REQUEST = {STAMP_W{1'b1}};
  localparam logic [COUNT_W-1:0] DONE_LIMIT = COUNT_W'(MAX_NODES);

  // Event codes carried on the mode field.
  localparam logic [2:0] MODE_OWN_REQ      = 3'd0;
  localparam logic [2:0] MODE_PEER_REQ     = 3'd1;
  localparam logic [2:0] MODE_PEER_REPLY   = 3'd2;
  localparam logic [2:0] MODE_PEER_RELEASE = 3'd3;
  localparam logic [2:0] MODE_PEER_DONE    = 3'd4;

  // Configuration register indexes.
  localparam logic REG_SELF_ID   = 1'b0;
  localparam logic REG_NUM_NODES = 1'b1;

  typedef struct packed {
    logic capture;
    logic apply;
    logic load_own;
    logic scan;
    logic finish;
  } lmx_cmd_t;

  typedef struct packed {
    logic try_scan;
    logic scan_done;
  } lmx_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/lamport_mutex_node.sv */
// Top level of one node of the Lamport distributed mutual exclusion scheme.
// Instantiates lmx_ctrl and lmx_dp; types and constants come from lmx_pkg.
//
//   Channel  Dir  Handshake             Payload
//   ev       in   ev_valid / ev_stall   mode, sender, stamp
//   res      out  res_valid / res_stall send_reply, reply_dest, grant, finished_count
//   cfg      in   cfg_we                cfg_index, cfg_data (self_id, num_nodes)
//
// An event that skips the grant test goes from capture through the update step to
// the finish step, which loads the result register; one that tests also loads its own
// stamp and scans participants 1 to num_nodes (capped at 15), one stamp pair a cycle.
// Synchronous reset brings all stamps, the done count and the config to their start values.
// A new event beat is taken while a finished result still waits in the output
// register; a stalled result only holds the block before it loads the next result.
`default_nettype none

module lamport_mutex_node
  import lmx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration writes.
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  // Event channel.
  input  wire logic               ev_valid,
  output logic                    ev_stall,
  input  wire logic [2:0]         mode,
  input  wire logic [NODE_W-1:0]  sender,
  input  wire logic [STAMP_W-1:0] stamp,
  // Result channel.
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic                    send_reply,
  output logic [NODE_W-1:0]       reply_dest,
  output logic                    grant,
  output logic [COUNT_W-1:0]      finished_count
);

  // The controller only steps through capture, update, own-stamp load, scan and finish; all
  // stored stamps and decisions live in the datapath.
  lmx_cmd_t cmd;
  lmx_sts_t sts;

  lmx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev_stall  (ev_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath updates the sender's entries, then, while this node waits,
  // reads its own stamp and walks the participants to find the smallest
  // request and any peer heard no later than the own stamp.
  lmx_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .sender         (sender),
    .stamp          (stamp),
    .cmd            (cmd),
    .sts            (sts),
    .send_reply     (send_reply),
    .reply_dest     (reply_dest),
    .grant          (grant),
    .finished_count (finished_count)
  );

endmodule

`default_nettype wire

/* hw/rtl/lmx_ctrl.sv */
// Sequencing state machine for the mutual exclusion node.
// Depends on lmx_pkg for the command and status structs.
`default_nettype none

module lmx_ctrl
  import lmx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     ev_valid,
  output logic          ev_stall,
  output logic          res_valid,
  input  wire logic     res_stall,
  input  wire lmx_sts_t sts,
  output lmx_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_OWN,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !res_valid || !res_stall;
  assign ev_stall  = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.capture  = ev_valid;
      S_APPLY:  cmd.apply    = 1'b1;
      S_OWN:    cmd.load_own = 1'b1;
      S_SCAN:   cmd.scan     = 1'b1;
      S_FINISH: cmd.finish   = slot_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && slot_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ev_valid) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= sts.try_scan ? S_OWN : S_FINISH;
        end
        S_OWN: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted beat always moves straight on to the state update.
  a_accept_to_apply: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && !ev_stall) |=> (state == S_APPLY))
    else $error("accepted event did not enter the update step");
`endif

endmodule

`default_nettype wire

/* hw/rtl/lmx_dp.sv */
// Datapath of the mutual exclusion node: configuration, queue and heard stamps,
// the one-entry-per-cycle grant scan and the result register. Depends on lmx_pkg.
`default_nettype none

module lmx_dp
  import lmx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic [2:0]         mode,
  input  wire logic [NODE_W-1:0]  sender,
  input  wire logic [STAMP_W-1:0] stamp,
  input  wire lmx_cmd_t           cmd,
  output lmx_sts_t                sts,
  output logic                    send_reply,
  output logic [NODE_W-1:0]       reply_dest,
  output logic                    grant,
  output logic [COUNT_W-1:0]      finished_count
);

  logic [NODE_W-1:0]  self_id;
  logic [NODE_W-1:0]  num_nodes;
  logic [STAMP_W-1:0] req_stamps [MAX_NODES];
  logic [STAMP_W-1:0] heard_stamps [MAX_NODES];
  logic [COUNT_W-1:0] finished;
  logic               waiting;

  logic [2:0]         ev_mode;
  logic [NODE_W-1:0]  ev_sender;
  logic [STAMP_W-1:0] ev_stamp;

  logic [STAMP_W-1:0] own;
  logic [STAMP_W:0]   best;
  logic [NODE_W-1:0]  winner;
  logic [NODE_W-1:0]  idx;
  logic               fail;
  logic               scanned;

  logic [NODE_W-1:0]  lim;
  logic               self_ok;
  logic               evt_ok;
  logic [NODE_W-1:0]  rd_idx;
  logic [STAMP_W-1:0] rd_req;
  logic [STAMP_W-1:0] rd_heard;
  logic               grant_d;

  // The scan never reaches past the last stored entry.
  assign lim = ({1'b0, num_nodes} > 5'(MAX_NODES - 1)) ? NODE_W'(MAX_NODES - 1) : num_nodes;
  assign self_ok = (self_id != '0) && (self_id <= lim);
  assign evt_ok  = (ev_mode >= MODE_PEER_REQ) && (ev_mode <= MODE_PEER_DONE) &&
                   (ev_sender != '0) && (ev_sender <= num_nodes) &&
                   (ev_sender != self_id) && ({1'b0, ev_sender} < 5'(MAX_NODES));

  assign rd_idx   = cmd.load_own ? self_id : idx;
  assign rd_req   = req_stamps[rd_idx];
  assign rd_heard = heard_stamps[rd_idx];

  assign sts.try_scan  = evt_ok && waiting && self_ok;
  assign sts.scan_done = (idx == lim);

  assign grant_d = scanned && !fail && (winner == self_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id   <= NODE_W'(1);
      num_nodes <= NODE_W'(1);
      for (int i = 0; i < MAX_NODES; i++) begin
        req_stamps[i]   <= NO_REQUEST;
        heard_stamps[i] <= '0;
      end
      finished <= COUNT_W'(1);
      waiting  <= 1'b0;
      scanned  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SELF_ID:   self_id   <= cfg_data;
          REG_NUM_NODES: num_nodes <= cfg_data;
          default:       self_id   <= self_id;
        endcase
      end

      if (cmd.capture) begin
        ev_mode   <= mode;
        ev_sender <= sender;
        ev_stamp  <= stamp;
        scanned   <= 1'b0;
      end

      if (cmd.apply) begin
        if (ev_mode == MODE_OWN_REQ) begin
          req_stamps[self_id] <= ev_stamp;
          waiting             <= 1'b1;
        end else if (evt_ok) begin
          heard_stamps[ev_sender] <= ev_stamp;
          case (ev_mode)
            MODE_PEER_REQ:     req_stamps[ev_sender] <= ev_stamp;
            MODE_PEER_RELEASE: req_stamps[ev_sender] <= NO_REQUEST;
            MODE_PEER_DONE: begin
              if (finished < DONE_LIMIT) begin
                finished <= finished + COUNT_W'(1);
              end
            end
            default: finished <= finished;
          endcase
        end
      end

      if (cmd.load_own) begin
        own     <= rd_req;
        best    <= {1'b1, {STAMP_W{1'b0}}};
        winner  <= '0;
        fail    <= 1'b0;
        idx     <= NODE_W'(1);
        scanned <= 1'b1;
      end

      if (cmd.scan) begin
        // A peer heard at or before the own stamp blocks entry.
        if ((idx != self_id) && (rd_heard != '0) && (rd_heard <= own)) begin
          fail <= 1'b1;
        end
        // Strict compare keeps the lowest index on a tie.
        if ({1'b0, rd_req} < best) begin
          best   <= {1'b0, rd_req};
          winner <= idx;
        end
        idx <= idx + NODE_W'(1);
      end

      if (cmd.finish) begin
        send_reply     <= evt_ok && (ev_mode == MODE_PEER_REQ);
        reply_dest     <= (evt_ok && (ev_mode == MODE_PEER_REQ)) ? ev_sender : '0;
        grant          <= grant_d;
        finished_count <= finished;
        if (grant_d) begin
          waiting <= 1'b0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (idx != '0) && (idx <= lim))
    else $error("scan index left the participant range");

  a_grant_needs_wait: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && grant_d) |-> (evt_ok && waiting && self_ok))
    else $error("grant issued without a pending own request");

  a_finished_range: assert property (@(posedge clk) disable iff (rst)
    (finished != '0) && (finished <= DONE_LIMIT))
    else $error("finished node count out of range");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for lamport_mutex_node: drives event beats, predicts every result beat
// in a model of its own and checks them field by field. Depends on lmx_pkg and the RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmx_pkg::*;

  // Wait after the last result before touching the config registers or ending the
  // run.
  localparam int SETTLE_CYCLES = 30;
  // Length of the long receiver hold-off used to fill the block up.
  localparam int HOLD_CYCLES   = 300;
  // Input beats per random traffic phase.
  localparam int PHASE_EVENTS  = 80;

  // One event beat as offered on the input channel.
  typedef struct {
    logic [2:0]         op;
    logic [NODE_W-1:0]  src;
    logic [STAMP_W-1:0] ts;
  } lamport_ev_t;

  // One result beat as seen on the output channel.
  typedef struct packed {
    logic               send_reply;
    logic [NODE_W-1:0]  reply_dest;
    logic               grant;
    logic [COUNT_W-1:0] finished_count;
  } node_answer_t;

  // All inputs start at known values; reset is asserted from time zero.
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_SELF_ID;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                ev_valid = 1'b0;
  logic                ev_stall;
  logic [2:0]          mode = MODE_OWN_REQ;
  logic [NODE_W-1:0]   sender = '0;
  logic [STAMP_W-1:0]  stamp = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic                send_reply;
  logic [NODE_W-1:0]   reply_dest;
  logic                grant;
  logic [COUNT_W-1:0]  finished_count;

  lamport_mutex_node u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the node's queue, last-heard stamps,
  // done count, waiting flag and configuration.
  // ---------------------------------------------------------------------------
  logic [STAMP_W-1:0] queue_stamp [MAX_NODES];
  logic [STAMP_W-1:0] heard_stamp [MAX_NODES];
  logic [COUNT_W-1:0] done_nodes;
  logic               is_waiting;
  logic [CFG_W-1:0]   cfg_self;
  logic [CFG_W-1:0]   cfg_count;

  node_answer_t pending_answers [$];
  int           errors = 0;

  // Idling knobs. The sender's is read only by the stimulus process; the
  // receiver's by the stall process.
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  // Toggling hold_req asks the stall process for one long hold-off.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  function automatic void clear_node_model();
    for (int i = 0; i < MAX_NODES; i++) begin
      queue_stamp[i] = NO_REQUEST;
      heard_stamp[i] = '0;
    end
    done_nodes = 1;
    is_waiting = 1'b0;
    cfg_self   = 1;
    cfg_count  = 1;
  endfunction

  // The node may enter when no active peer was last heard at or before its own
  // stamp and it holds the smallest queue stamp, lowest index winning ties.
  function automatic logic holds_lowest_stamp();
    int                 lim;
    int                 best;
    int                 winner;
    logic [STAMP_W-1:0] own;
    lim = (cfg_count > MAX_NODES - 1) ? MAX_NODES - 1 : cfg_count;
    if (cfg_self == 0 || cfg_self > lim) return 1'b0;
    own    = queue_stamp[cfg_self];
    best   = int'(NO_REQUEST) + 1;
    winner = 0;
    for (int i = 1; i <= lim; i++) begin
      if (i != cfg_self && heard_stamp[i] != 0 && heard_stamp[i] <= own) return 1'b0;
      if (queue_stamp[i] < best) begin
        best   = queue_stamp[i];
        winner = i;
      end
    end
    return winner == cfg_self;
  endfunction

  // Applies one accepted event to the predictor and returns the result it causes.
  function automatic node_answer_t lamport_step(logic [2:0] op, logic [NODE_W-1:0] src,
                                                logic [STAMP_W-1:0] ts);
    node_answer_t ans;
    logic         peer_ok;
    ans = '0;
    if (op == MODE_OWN_REQ) begin
      // A repeated own request simply overwrites the own stamp.
      queue_stamp[cfg_self] = ts;
      is_waiting = 1'b1;
    end else if (op <= MODE_PEER_DONE) begin
      // Peer events from index zero, from beyond the participant set or from
      // this node itself are dropped without any effect.
      peer_ok = src != 0 && src <= cfg_count && src != cfg_self;
      if (peer_ok) begin
        heard_stamp[src] = ts;
        case (op)
          MODE_PEER_REQ: begin
            queue_stamp[src] = ts;
            ans.send_reply   = 1'b1;
            ans.reply_dest   = src;
          end
          MODE_PEER_RELEASE: begin
            queue_stamp[src] = NO_REQUEST;
          end
          MODE_PEER_DONE: begin
            if (done_nodes < DONE_LIMIT) done_nodes++;
          end
          default: ;
        endcase
        if (is_waiting && holds_lowest_stamp()) begin
          is_waiting = 1'b0;
          ans.grant  = 1'b1;
        end
      end
    end
    ans.finished_count = done_nodes;
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls at random or for one long hold-off, and
  // every accepted result beat is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  function automatic void compare_field(string what, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    node_answer_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, expected none, actual %b",
                 $time, {send_reply, reply_dest, grant, finished_count});
        errors++;
      end else begin
        want = pending_answers.pop_front();
        compare_field("send_reply", want.send_reply, send_reply);
        compare_field("reply_dest", want.reply_dest, reply_dest);
        compare_field("grant", want.grant, grant);
        compare_field("finished_count", want.finished_count, finished_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every call starts right after a rising edge. The event
  // valid is left high after an accepted beat; the next call either offers the
  // next beat or lowers it, so valid gets only one assignment per time step.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [2:0] op, input logic [NODE_W-1:0] src,
                            input logic [STAMP_W-1:0] ts);
    while ($urandom_range(99) < snd_idle_pct) begin
      ev_valid <= 1'b0;
      @(posedge clk);
    end
    ev_valid <= 1'b1;
    mode     <= op;
    sender   <= src;
    stamp    <= ts;
    @(posedge clk);
    while (ev_stall) @(posedge clk);
    pending_answers.push_back(lamport_step(op, src, ts));
  endtask

  task automatic send_noise();
    send_event(3'($urandom_range(7)), NODE_W'($urandom_range(15)),
               STAMP_W'($urandom_range(32767)));
  endtask

  // Lowers valid, waits for every outstanding result and lets the block settle.
  task automatic wait_idle();
    ev_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle; both registers go back to
  // back, keeping the write enable high across both writes.
  task automatic set_config(input logic [CFG_W-1:0] self_v, input logic [CFG_W-1:0] num_v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SELF_ID;
    cfg_data  <= self_v;
    @(posedge clk);
    cfg_self  = self_v;
    cfg_index <= REG_NUM_NODES;
    cfg_data  <= num_v;
    @(posedge clk);
    cfg_count = num_v;
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_stall_pct <= rcv;
  endtask

  // One well-formed round of the protocol: an own request, then every peer
  // answers in random order. Some peers first queue a request of their own
  // (sometimes at the very same stamp, to hit the tie break) and release it at
  // the end, which is what finally lets the grant through. A little noise is
  // mixed in.
  task automatic run_round(inout int sent);
    int          peers [$];
    lamport_ev_t now_q [$];
    lamport_ev_t late_q [$];
    int          j;
    int          tmp;
    int          own;
    int          pick;
    for (int i = 1; i <= cfg_count; i++) begin
      if (i != cfg_self) peers.push_back(i);
    end
    for (int k = peers.size() - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      tmp      = peers[k];
      peers[k] = peers[j];
      peers[j] = tmp;
    end
    own = $urandom_range(30000);
    // The sender field of an own request is unused; it still gets random bits.
    now_q.push_back('{MODE_OWN_REQ, NODE_W'($urandom_range(15)), STAMP_W'(own)});
    foreach (peers[k]) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        now_q.push_back('{MODE_PEER_REQ, NODE_W'(peers[k]),
                          STAMP_W'(($urandom_range(4) == 0) ? own : $urandom_range(own + 300))});
        if ($urandom_range(1) == 1) begin
          now_q.push_back('{MODE_PEER_REPLY, NODE_W'(peers[k]),
                            STAMP_W'(own + $urandom_range(1000, 1))});
        end
        late_q.push_back('{MODE_PEER_RELEASE, NODE_W'(peers[k]),
                           STAMP_W'(own + $urandom_range(1000, 1))});
      end else if (pick < 35) begin
        now_q.push_back('{MODE_PEER_DONE, NODE_W'(peers[k]),
                          STAMP_W'(own + $urandom_range(1000, 1))});
      end else begin
        now_q.push_back('{MODE_PEER_REPLY, NODE_W'(peers[k]),
                          STAMP_W'(own + $urandom_range(1000, 1))});
      end
      if ($urandom_range(9) == 0) begin
        now_q.push_back('{3'($urandom_range(7)), NODE_W'($urandom_range(15)),
                          STAMP_W'($urandom_range(32767))});
      end
    end
    foreach (now_q[k]) send_event(now_q[k].op, now_q[k].src, now_q[k].ts);
    foreach (late_q[k]) send_event(late_q[k].op, late_q[k].src, late_q[k].ts);
    sent += now_q.size() + late_q.size();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked walk through the protocol: ignored events, a grant held back by
  // an old last-heard stamp, a grant held back by a lower queued request, the
  // tie break, and bad configurations.
  task automatic test_directed();
    // Reset config: a single participant, so every peer event is dropped.
    send_event(MODE_OWN_REQ, 4'd0, 15'd0);
    send_event(MODE_PEER_REPLY, 4'd1, 15'd5);
    send_event(MODE_PEER_REQ, 4'd2, 15'd5);
    send_event(3'd5, 4'd0, 15'd0);
    send_event(3'd6, 4'd3, 15'd9);
    send_event(3'd7, 4'd15, 15'd32767);

    set_config(4'd2, 4'd3);
    send_event(MODE_OWN_REQ, 4'd0, 15'd100);
    // Peer 1 heard at 50 blocks the grant until it is heard again later.
    send_event(MODE_PEER_REPLY, 4'd1, 15'd50);
    send_event(MODE_PEER_REPLY, 4'd3, 15'd200);
    send_event(MODE_PEER_REPLY, 4'd1, 15'd150);
    // Not waiting any more: replies still go out, nothing is granted.
    send_event(MODE_PEER_REQ, 4'd1, 15'd32767);
    send_event(MODE_PEER_REQ, 4'd3, 15'd0);
    // Peer 3 queued at stamp 0 holds us off until it releases.
    send_event(MODE_OWN_REQ, 4'd0, 15'd10);
    send_event(MODE_PEER_REPLY, 4'd1, 15'd20);
    send_event(MODE_PEER_RELEASE, 4'd3, 15'd30);
    send_event(MODE_PEER_REPLY, 4'd0, 15'd40);
    send_event(MODE_PEER_DONE, 4'd1, 15'd41);
    send_event(MODE_PEER_DONE, 4'd3, 15'd42);
    // Equal stamps: the lower index of peer 1 wins, so only its release grants.
    send_event(MODE_OWN_REQ, 4'd0, 15'd500);
    send_event(MODE_PEER_REQ, 4'd1, 15'd500);
    send_event(MODE_PEER_REPLY, 4'd3, 15'd600);
    send_event(MODE_PEER_REPLY, 4'd1, 15'd700);
    send_event(MODE_PEER_RELEASE, 4'd1, 15'd800);

    // Largest index, and an index of zero with an empty participant set.
    set_config(4'd15, 4'd15);
    send_event(MODE_PEER_REPLY, 4'd14, 15'd1);
    send_event(MODE_OWN_REQ, 4'd0, 15'd20000);
    send_event(MODE_PEER_REQ, 4'd15, 15'd3);
    set_config(4'd0, 4'd0);
    send_event(MODE_OWN_REQ, 4'd0, 15'd7);
    send_event(MODE_PEER_REPLY, 4'd1, 15'd9);
  endtask

  // Random protocol rounds under one idling setting and one configuration.
  task automatic test_traffic(input int snd, input int rcv, input logic [CFG_W-1:0] self_v,
                              input logic [CFG_W-1:0] num_v);
    int sent;
    sent = 0;
    set_config(self_v, num_v);
    set_idling(snd, rcv);
    while (sent < PHASE_EVENTS) run_round(sent);
  endtask

  // Own indices that can never win, and an empty participant set.
  task automatic test_bad_config();
    set_idling(36, 36);
    set_config(4'd0, 4'd15);
    repeat (8) send_noise();
    set_config(4'd12, 4'd3);
    send_event(MODE_OWN_REQ, 4'd0, 15'd1);
    repeat (6) send_noise();
    set_config(4'd5, 4'd0);
    repeat (6) send_noise();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats, so the result register fills, the next event waits in the block and the input stalls.
  task automatic test_backpressure();
    int sent;
    sent = 0;
    set_config(4'd4, 4'd6);
    set_idling(0, 0);
    hold_req <= ~hold_req;
    while (sent < 40) run_round(sent);
  endtask

  initial begin
    clear_node_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    // No idling, sender idle, receiver stalling, then both.
    test_traffic(0, 0, 4'd1, 4'd2);
    test_traffic(0, 0, 4'd15, 4'd15);
    test_traffic(80, 0, 4'd4, 4'd9);
    test_traffic(80, 0, 4'd2, 4'd2);
    test_traffic(0, 80, 4'd9, 4'd15);
    test_traffic(0, 80, 4'd1, 4'd15);
    test_traffic(36, 36, 4'd13, 4'd14);
    test_traffic(36, 36, 4'd6, 4'd8);
    test_bad_config();
    test_backpressure();

    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/lmx_pkg.sv
hw/rtl/lmx_ctrl.sv
hw/rtl/lmx_dp.sv
hw/rtl/lamport_mutex_node.sv
dv/tb.sv
